@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps

package jsu_pkg;

   // Result buffer sizing: one input byte yields at most three results
   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 4;

   // Decoder modes, one-hot
   typedef enum logic [2:0] {
      MODE_COPY = 3'b001,
      MODE_ESC  = 3'b010,
      MODE_HEX  = 3'b100
   } mode_type;

   // Result kinds as carried on tuser
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;
   localparam logic [7:0] CHAR_U     = 8'h75;

   typedef struct packed {
      logic       last;
      kind_type   kind;
      logic [7:0] data;
   } rsp_entry_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } esc_char_type;

   // ASCII hex digit, either case
   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type r;
      r.hit   = 1'b0;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.hit   = 1'b1;
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.hit   = 1'b1;
         r.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.hit   = 1'b1;
         r.value = 4'(c - 8'h37);
      end
      return r;
   endfunction

   // Single-character escapes after a backslash
   function automatic esc_char_type simple_escape(input logic [7:0] c);
      esc_char_type r;
      r.hit   = 1'b1;
      r.value = c;
      unique case (c)
         8'h22, 8'h27, 8'h2F, 8'h5C: r.value = c;
         8'h61:   r.value = 8'h07;
         8'h62:   r.value = 8'h08;
         8'h66:   r.value = 8'h0C;
         8'h6E:   r.value = 8'h0A;
         8'h72:   r.value = 8'h0D;
         8'h74:   r.value = 8'h09;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

@@ sv/json_string_unescape_utf8_core.sv @@
`timescale 1ns / 1ps

// JSON string body unescaper. Feed the bytes after the opening quote, one per
// transaction on req_. Plain bytes come out unchanged; backslash escapes are
// decoded, and a \uXXXX escape is turned into its one to three byte UTF-8
// form when the fourth hex digit arrives. An unescaped quote gives a single
// "complete" result, a zero byte, unknown escape or bad hex digit a single
// "syntax error" result; either way the decoder is then ready for a new
// string. Each input byte is decoded in the cycle it is accepted and its
// results are written to a four-entry result buffer, from which one result
// leaves per cycle while rsp_tready is high. A byte is accepted whenever
// the buffer has room for three results, so streams of plain bytes run at
// one byte per cycle while rsp_tready is high; a byte that expands into two
// or three results holds the input while the single result port drains the buffer.
module json_string_unescape_utf8_core
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int NUM_W = $clog2(MAX_RESULTS + 1);

   mode_type         mode_ff, mode_in;
   logic [1:0]       hex_cnt_ff, hex_cnt_in;
   logic [11:0]      cp_ff, cp_in;

   rsp_entry_type    fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [NUM_W-1:0] res_num;
   logic [7:0]       res_data [MAX_RESULTS];
   kind_type         res_kind [MAX_RESULTS];
   rsp_entry_type    res_ent  [MAX_RESULTS];
   hex_digit_type    hd;
   esc_char_type     ec;
   logic [15:0]      cp_full;

   assign req_tready = cnt_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_tvalid & rsp_tready;

   // Head of the result buffer drives the output channel
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].data;
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

   assign hd      = hex_digit(req_tdata);
   assign ec      = simple_escape(req_tdata);
   assign cp_full = {cp_ff, hd.value};

   // Byte decoder: next state and up to three results
   always_comb begin
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      cp_in      = cp_ff;
      res_num    = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_data[i] = 8'h00;
         res_kind[i] = KIND_DATA;
      end
      unique case (mode_ff)
         MODE_ESC: begin
            mode_in    = MODE_COPY;
            hex_cnt_in = 2'd0;
            cp_in      = 12'd0;
            res_num    = NUM_W'(1);
            if (ec.hit) begin
               res_data[0] = ec.value;
            end else if (req_tdata == CHAR_U) begin
               mode_in = MODE_HEX;
               res_num = '0;
            end else begin
               res_kind[0] = KIND_ERR;
            end
         end
         MODE_HEX: begin
            if (!hd.hit) begin
               mode_in     = MODE_COPY;
               hex_cnt_in  = 2'd0;
               cp_in       = 12'd0;
               res_num     = NUM_W'(1);
               res_kind[0] = KIND_ERR;
            end else if (hex_cnt_ff != 2'd3) begin
               hex_cnt_in = hex_cnt_ff + 2'd1;
               cp_in      = cp_full[11:0];
            end else begin
               mode_in    = MODE_COPY;
               hex_cnt_in = 2'd0;
               cp_in      = 12'd0;
               // UTF-8 encoding of the finished code point
               if (cp_full <= 16'h007F) begin
                  res_num     = NUM_W'(1);
                  res_data[0] = cp_full[7:0];
               end else if (cp_full <= 16'h07FF) begin
                  res_num     = NUM_W'(2);
                  res_data[0] = {3'b110, cp_full[10:6]};
                  res_data[1] = {2'b10, cp_full[5:0]};
               end else begin
                  res_num     = NUM_W'(3);
                  res_data[0] = {4'b1110, cp_full[15:12]};
                  res_data[1] = {2'b10, cp_full[11:6]};
                  res_data[2] = {2'b10, cp_full[5:0]};
               end
            end
         end
         default: begin
            // copy mode
            mode_in    = MODE_COPY;
            hex_cnt_in = 2'd0;
            cp_in      = 12'd0;
            res_num    = NUM_W'(1);
            priority if (req_tdata == CHAR_NUL) begin
               res_kind[0] = KIND_ERR;
            end else if (req_tdata == CHAR_QUOTE) begin
               res_kind[0] = KIND_DONE;
            end else if (req_tdata == CHAR_BSL) begin
               mode_in = MODE_ESC;
               res_num = '0;
            end else begin
               res_data[0] = req_tdata;
            end
         end
      endcase
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_ent[i].data = res_data[i];
         res_ent[i].kind = res_kind[i];
         res_ent[i].last = res_num == NUM_W'(i + 1);
      end
   end

   // Buffer pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_num);
         cnt_in    = cnt_in + CNT_W'(res_num);
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         cnt_in    = cnt_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_COPY;
         hex_cnt_ff <= 2'd0;
         cp_ff      <= 12'd0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         if (req_xfer) begin
            mode_ff    <= mode_in;
            hex_cnt_ff <= hex_cnt_in;
            cp_ff      <= cp_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Result buffer storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (NUM_W'(i) < res_num) begin
               fifo_ff[PTR_W'(wr_ptr_ff + PTR_W'(i))] <= res_ent[i];
            end
         end
      end
   end

   // Buffer never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result buffer count out of range");

   // Hex digit count only moves inside a \u escape
   a_hex_mode: assert property (@(posedge clock) disable iff (reset)
      hex_cnt_ff != 2'd0 |-> mode_ff == MODE_HEX)
      else $error("hex digit count outside hex mode");

   // Status results are single, final and carry a zero byte
   a_status_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |-> rsp_tdata == 8'h00 && rsp_tlast)
      else $error("malformed status result");

   // A closing quote in copy mode leaves the decoder in copy mode
   a_quote_done: assert property (@(posedge clock) disable iff (reset)
      req_xfer && mode_ff == MODE_COPY && req_tdata == CHAR_QUOTE
      |=> mode_ff == MODE_COPY)
      else $error("decoder left copy mode on closing quote");

endmodule
